/* src/tcw_pkg.sv */
// Package for the text console writer: constants, byte codes, shared types.
// No dependencies.
package tcw_pkg;
    localparam int COLUMNS_DEF      = 80;
    localparam int ROWS_DEF         = 25;
    localparam int MEMORY_CELLS_DEF = 16384;
    localparam int PAGE_STEP_DEF    = 80;
    localparam int AW               = 14;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_FF  = 8'd12;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_DEL = 8'd127;

    localparam logic CFG_TEXT_ATTR  = 1'b0;
    localparam logic CFG_BLANK_CELL = 1'b1;

    localparam logic [15:0] BLANK_RESET = 16'd1824;
    localparam logic [7:0]  ATTR_RESET  = 8'd7;

    // queued command between front and back
    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic [13:0] cell_address;
    } t_cmd;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [13:0] screen_start;
        logic [13:0] cursor_address;
    } t_res;
endpackage

/* src/tcw_if.sv */
// Valid/ready channel interfaces for the text console writer.
// Depends on tcw_pkg.
interface tcw_in_if import tcw_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  char_code;
    logic [13:0] cell_address;
    logic        end_of_write;
    modport source (output valid, mode, char_code, cell_address, end_of_write, input ready);
    modport sink (input valid, mode, char_code, cell_address, end_of_write, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] cell_data;
    logic [13:0] screen_start;
    logic [13:0] cursor_address;
    modport source (output valid, cell_data, screen_start, cursor_address, input ready);
    modport sink (input valid, cell_data, screen_start, cursor_address, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/tcw_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* src/tcw_front.sv */
// Front end: accepts items into a two-entry queue for the back end.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
        if (w_push) begin
            r_q[r_rd ^ r_cnt[0]] <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
endmodule

/* src/tcw_back.sv */
// Back end: interprets bytes, reads and writes cells, scrolls, clears after reset.
// Depends on tcw_pkg and tcw_ram.
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int ROWS         = ROWS_DEF,
    parameter int MEMORY_CELLS = MEMORY_CELLS_DEF,
    parameter int PAGE_STEP    = PAGE_STEP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_attr,
    input  logic [15:0] i_blank,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);
    localparam int MW = $clog2(MEMORY_CELLS);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int LEN = (ROWS - 1) * COLUMNS;
    localparam logic [AW:0] PAGE_END = (AW+1)'(PAGE_STEP + ROWS * COLUMNS);
    localparam logic [AW:0] MEMN = (AW+1)'(MEMORY_CELLS);
    // page step beyond one row: forward page overlaps the source, so copy from the end down
    localparam logic COPY_DOWN = (PAGE_STEP > COLUMNS);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RDW  = 4'd2;
    localparam logic [3:0] S_RDD  = 4'd3;
    localparam logic [3:0] S_CPR  = 4'd4;
    localparam logic [3:0] S_CPW  = 4'd5;
    localparam logic [3:0] S_BLK  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]    r_st;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] r_start, r_src, r_dst;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_rowbase;
    logic          r_copy_ok;
    logic          r_down;
    logic [AW-1:0] r_blk_base;
    logic [AW-1:0] r_raddr;
    logic [15:0]   r_data;
    logic          r_ovalid;
    logic          w_we;
    logic [MW-1:0] w_addr;
    logic [15:0]   w_wdata, w_rdata;
    logic [AW:0]   w_cur;
    logic [AW:0]   w_page;

    assign w_cur  = {1'b0, r_start} + {1'b0, r_rowbase} + (AW+1)'(r_col);
    assign w_page = {1'b0, r_start} + PAGE_END;

    tcw_ram #(.WIDTH(16), .DEPTH(MEMORY_CELLS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    // memory port mux
    always_comb begin
        w_we = 1'b0;
        w_addr = MW'(w_cur);
        w_wdata = i_blank;
        unique case (r_st)
            S_CLR: begin
                w_we = 1'b1;
                w_addr = MW'(r_cnt);
                w_wdata = BLANK_RESET;
            end
            S_RDW: w_addr = MW'(r_raddr);
            S_CPR: w_addr = MW'(r_src);
            S_CPW: begin
                w_we = 1'b1;
                w_addr = MW'(r_dst);
                w_wdata = w_rdata;
            end
            S_BLK: begin
                w_addr = MW'(r_blk_base + AW'(r_cnt));
                w_we = ({1'b0, r_blk_base} + r_cnt) < MEMN;
            end
            S_IDLE: begin
                if (i_valid && o_ready && !i_cmd.mode) begin
                    priority if (i_cmd.char_code == CH_NUL || i_cmd.char_code == CH_LF ||
                                 i_cmd.char_code == CH_CR || i_cmd.char_code == CH_FF) begin
                        w_we = 1'b0;
                    end else if (i_cmd.char_code == CH_BS) begin
                        w_addr = MW'(w_cur - 1'b1);
                        w_we = (r_col != '0) && ((w_cur - 1'b1) < MEMN);
                    end else if (i_cmd.char_code == CH_DEL) begin
                        w_we = w_cur < MEMN;
                    end else begin
                        w_wdata = {i_attr, i_cmd.char_code};
                        w_we = w_cur < MEMN;
                    end
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    assign o_ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_res.cell_data = r_data;
    assign o_res.screen_start = r_start;
    assign o_res.cursor_address = AW'(w_cur);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_cnt <= '0;
            r_start <= '0;
            r_col <= '0;
            r_row <= '0;
            r_rowbase <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MEMN - 1'b1) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_data <= '0;
                        if (i_cmd.mode) begin
                            r_raddr <= i_cmd.cell_address;
                            r_st <= S_RDW;
                        end else begin
                            // line feed needed?
                            logic lf;
                            lf = 1'b0;
                            priority if (i_cmd.char_code == CH_NUL) begin
                            end else if (i_cmd.char_code == CH_LF) begin
                                r_col <= '0;
                                lf = 1'b1;
                            end else if (i_cmd.char_code == CH_CR) begin
                                r_col <= '0;
                            end else if (i_cmd.char_code == CH_BS) begin
                                if (r_col != '0) r_col <= r_col - 1'b1;
                            end else if (i_cmd.char_code == CH_DEL) begin
                            end else if (i_cmd.char_code == CH_FF) begin
                                lf = 1'b1;
                            end else if (int'(r_col) == COLUMNS - 1) begin
                                r_col <= '0;
                                if (int'(r_row) == ROWS - 1) lf = 1'b1;
                                else begin
                                    r_row <= r_row + 1'b1;
                                    r_rowbase <= r_rowbase + AW'(COLUMNS);
                                end
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            if (lf && int'(r_row) != ROWS - 1) begin
                                r_row <= r_row + 1'b1;
                                r_rowbase <= r_rowbase + AW'(COLUMNS);
                                r_ovalid <= 1'b1;
                            end else if (lf) begin
                                r_copy_ok <= ({1'b0, r_start} + (AW+1)'(COLUMNS + LEN)) <= MEMN;
                                if (w_page <= MEMN) begin
                                    r_down <= COPY_DOWN;
                                    r_src <= COPY_DOWN ? r_start + AW'(COLUMNS + LEN - 1)
                                                       : r_start + AW'(COLUMNS);
                                    r_dst <= COPY_DOWN ? r_start + AW'(PAGE_STEP + LEN - 1)
                                                       : r_start + AW'(PAGE_STEP);
                                    r_start <= r_start + AW'(PAGE_STEP);
                                    r_blk_base <= r_start + AW'(PAGE_STEP + LEN);
                                end else begin
                                    r_down <= 1'b0;
                                    r_src <= r_start + AW'(COLUMNS);
                                    r_dst <= '0;
                                    r_start <= '0;
                                    r_blk_base <= AW'(LEN);
                                end
                                r_cnt <= '0;
                                r_st <= S_CPR;
                            end else begin
                                r_ovalid <= 1'b1;
                            end
                        end
                    end
                end
                S_RDW: begin
                    r_st <= S_RDD;
                end
                S_RDD: begin
                    r_data <= (r_raddr < MEMN[AW-1:0] || MEMN[AW]) ? w_rdata : '0;
                    r_ovalid <= 1'b1;
                    r_st <= S_OUT;
                end
                S_CPR: begin
                    if (!r_copy_ok) begin
                        r_cnt <= '0;
                        r_st <= S_BLK;
                    end else begin
                        r_st <= S_CPW;
                    end
                end
                S_CPW: begin
                    r_src <= r_down ? r_src - 1'b1 : r_src + 1'b1;
                    r_dst <= r_down ? r_dst - 1'b1 : r_dst + 1'b1;
                    if (r_cnt == (AW+1)'(LEN - 1)) begin
                        r_cnt <= '0;
                        r_st <= S_BLK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_st <= S_CPR;
                    end
                end
                S_BLK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (AW+1)'(COLUMNS - 1)) begin
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                S_OUT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RDD) |=> r_ovalid) else $error("read gave no result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready) else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < ROWS) && (int'(r_col) < COLUMNS)) else $error("cursor out of page");
endmodule

/* src/text_console_writer_core.sv */
// Text console writer top level: front queue, back sequencer, config registers.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_back.
//
// A write byte's result is registered as the item is accepted, or after the scroll that it
// starts; a read passes through S_RDW and S_RDD before its result is registered. The back
// end takes its next item the cycle after a result leaves, so it takes no new item while
// the last one's result waits. A scroll holds the back end while the single memory port
// does one read and one write per copied cell and then blanks the new bottom row. After
// reset a clearing pass blanks the memory before items are taken.
module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int ROWS         = ROWS_DEF,
    parameter int MEMORY_CELLS = MEMORY_CELLS_DEF,
    parameter int PAGE_STEP    = PAGE_STEP_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    tcw_in_if.sink    in_ch,
    tcw_out_if.source out_ch,
    tcw_cfg_if.sink   cfg_ch
);
    logic [7:0]  r_attr;
    logic [15:0] r_blank;
    t_cmd        w_in, w_q;
    t_res        w_res;
    logic        w_qv, w_qr;

    assign cfg_ch.ready = 1'b1;
    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr  <= ATTR_RESET;
            r_blank <= BLANK_RESET;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                CFG_TEXT_ATTR:  r_attr  <= cfg_ch.data[7:0];
                CFG_BLANK_CELL: r_blank <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    assign w_in = '{mode: in_ch.mode, char_code: in_ch.char_code,
                    cell_address: in_ch.cell_address};

    tcw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_cmd(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .MEMORY_CELLS(MEMORY_CELLS),
               .PAGE_STEP(PAGE_STEP)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_q),
        .i_attr(r_attr), .i_blank(r_blank), .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_res(w_res)
    );

    assign out_ch.cell_data      = w_res.cell_data;
    assign out_ch.screen_start   = w_res.screen_start;
    assign out_ch.cursor_address = w_res.cursor_address;
endmodule

/* tb/tb_text_console_writer_core.sv */
// Self-checking testbench for text_console_writer_core: control bytes, text,
// scrolling, page wrap-back, cell reads and both config registers.
// Depends on tcw_pkg, tcw_if and the core; a shadow terminal predicts each result.
`timescale 1ns / 1ps

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = MEMORY_CELLS_DEF;
    localparam int STEP  = PAGE_STEP_DEF;

    logic i_clk;
    logic i_rst_n;

    tcw_in_if  in_if ();
    tcw_out_if out_if ();
    tcw_cfg_if cfg_if ();

    text_console_writer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .cfg_ch  (cfg_if)
    );

    // shadow terminal state
    logic [15:0] shadow_cells [CELLS];
    logic [7:0]  shadow_attr;
    logic [15:0] shadow_blank;
    int unsigned shadow_start;
    int unsigned shadow_row;
    int unsigned shadow_col;

    t_res pending_results [$];
    int   error_count;
    int   burst_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #150_000_000;
        $display("tb_text_console_writer_core failed");
        $finish;
    end

    // ---------------------------------------------------------------- shadow model
    function automatic int unsigned shadow_cursor();
        return shadow_start + shadow_row * COLS + shadow_col;
    endfunction

    function automatic void shadow_put(int unsigned addr, logic [15:0] v);
        if (addr < CELLS) shadow_cells[addr] = v;
    endfunction

    function automatic void shadow_scroll();
        logic [15:0] row_buf [(ROWS-1)*COLS];
        int unsigned src;
        int unsigned dst;
        int unsigned len;
        src = shadow_start + COLS;
        len = (ROWS - 1) * COLS;
        if (shadow_start + STEP + ROWS * COLS <= CELLS) dst = shadow_start + STEP;
        else dst = 0;
        shadow_start = dst;
        if (src + len <= CELLS && dst + len <= CELLS) begin
            for (int i = 0; i < len; i++) row_buf[i] = shadow_cells[src + i];
            for (int i = 0; i < len; i++) shadow_cells[dst + i] = row_buf[i];
        end
        for (int i = 0; i < COLS; i++)
            shadow_put(shadow_start + (ROWS - 1) * COLS + i, shadow_blank);
    endfunction

    function automatic void shadow_line_feed();
        if (shadow_row + 1 < ROWS) shadow_row++;
        else shadow_scroll();
    endfunction

    function automatic void shadow_write_byte(logic [7:0] ch);
        case (ch)
            CH_NUL: ;
            CH_LF: begin
                shadow_col = 0;
                shadow_line_feed();
            end
            CH_CR: shadow_col = 0;
            CH_BS: begin
                if (shadow_col != 0) begin
                    shadow_col--;
                    shadow_put(shadow_cursor(), shadow_blank);
                end
            end
            CH_DEL: shadow_put(shadow_cursor(), shadow_blank);
            CH_FF: shadow_line_feed();
            default: begin
                shadow_put(shadow_cursor(), {shadow_attr, ch});
                if (shadow_row == ROWS - 1 && shadow_col == COLS - 1) begin
                    shadow_col = 0;
                    shadow_line_feed();
                end else if (shadow_col + 1 >= COLS) begin
                    shadow_col = 0;
                    shadow_row++;
                end else begin
                    shadow_col++;
                end
            end
        endcase
    endfunction

    // works out the result of one accepted item and queues it
    function automatic void predict_item(logic mode, logic [7:0] ch, logic [13:0] addr);
        t_res r;
        r.cell_data = 16'd0;
        if (mode) r.cell_data = shadow_cells[addr];
        else shadow_write_byte(ch);
        r.screen_start   = shadow_start[13:0];
        r.cursor_address = 14'(shadow_cursor());
        pending_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------- sender
    task automatic send_item(logic mode, logic [7:0] ch, logic [13:0] addr, logic eow);
        @(negedge i_clk);
        in_if.valid        = 1'b1;
        in_if.mode         = mode;
        in_if.char_code    = ch;
        in_if.cell_address = addr;
        in_if.end_of_write = eow;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        predict_item(mode, ch, addr);
        // burst / gap pacing
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
            repeat ($urandom_range(3) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 5))
                @(negedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
        end
    endtask

    task automatic put_char(logic [7:0] ch);
        send_item(1'b0, ch, 14'($urandom), 1'($urandom));
    endtask

    task automatic read_cell(logic [13:0] addr);
        send_item(1'b1, 8'($urandom), addr, 1'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == CFG_TEXT_ATTR) shadow_attr = value[7:0];
        else shadow_blank = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver
    // stall pattern: cycles through open, one-in-three and coin-toss regimes
    int unsigned stall_tick;
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case ((stall_tick / 300) % 3)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= (stall_tick % 3 == 0);
            default: out_if.ready <= 1'($urandom);
        endcase
    end

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h %h %h", $time,
                         out_if.cell_data, out_if.screen_start, out_if.cursor_address);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("cell_data", want.cell_data, out_if.cell_data);
                report_field("screen_start", want.screen_start, out_if.screen_start);
                report_field("cursor_address", want.cursor_address, out_if.cursor_address);
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_control_bytes();
        put_char(CH_BS);             // backspace at column 0 does nothing
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h01);
        put_char(CH_NUL);
        put_char(CH_BS);             // blanks the 0x01 cell
        put_char(CH_DEL);
        put_char(CH_CR);
        put_char(CH_FF);             // column kept
        put_char(8'h7E);
        put_char(CH_LF);
        read_cell(14'd0);
        read_cell(14'd1);
        read_cell(14'd2);
        read_cell(14'd16383);
        read_cell(14'd81);
    endtask

    task automatic test_registers();
        write_reg(CFG_TEXT_ATTR, 16'h00FF);
        write_reg(CFG_BLANK_CELL, 16'hFFFF);
        put_char(8'h80);
        put_char(CH_BS);
        put_char(8'h20);
        put_char(CH_DEL);
        read_cell(14'(shadow_cursor()));
        read_cell(14'(shadow_cursor() - 1));
        write_reg(CFG_TEXT_ATTR, 16'h0000);
        write_reg(CFG_BLANK_CELL, 16'h0000);
        put_char(8'h55);
        put_char(CH_BS);
        read_cell(14'(shadow_cursor()));
    endtask

    // last cell of the page forces CR+LF and a scroll; then form feed on the bottom row
    task automatic test_bottom_row();
        write_reg(CFG_TEXT_ATTR, 16'h001E);
        write_reg(CFG_BLANK_CELL, 16'h0720);
        while (shadow_row != ROWS - 1) put_char(CH_LF);
        while (!(shadow_row == ROWS - 1 && shadow_col == COLS - 1))
            put_char(8'($urandom_range(32, 126)));
        put_char(8'h5A);
        for (int i = 0; i < 5; i++) put_char(8'(8'h61 + i));
        put_char(CH_FF);
        for (int i = 0; i < 6; i++) read_cell(14'(shadow_start + (ROWS - 2) * COLS + i));
        read_cell(14'(shadow_start + (ROWS - 1) * COLS + 3));
    endtask

    task automatic random_phase(int count);
        int r;
        int call_left;
        logic [7:0] ch;
        call_left = 0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (call_left == 0) call_left = $urandom_range(1, 16);
            call_left--;
            if (r < 25) begin
                if (r < 15)
                    read_cell(14'(shadow_start + $urandom_range(ROWS * COLS - 1)));
                else
                    read_cell(14'($urandom));
            end else begin
                if (r < 28) ch = CH_LF;
                else if (r < 29) ch = CH_FF;
                else if (r < 33) ch = CH_CR;
                else if (r < 37) ch = CH_BS;
                else if (r < 40) ch = CH_DEL;
                else if (r < 41) ch = CH_NUL;
                else ch = 8'($urandom);
                send_item(1'b0, ch, 14'($urandom), call_left == 0);
            end
            if (i == count / 2) wait_drained();
        end
    endtask

    // scroll by line feeds until the page no longer fits and the start wraps to 0
    task automatic test_page_wrap();
        int unsigned last_start;
        last_start = 0;
        while (shadow_row != ROWS - 1) put_char(CH_LF);
        put_char(8'h23);
        do begin
            last_start = shadow_start;
            put_char(CH_LF);
        end while (!(shadow_start == 0 && last_start != 0));
        for (int i = 0; i < 4; i++) read_cell(14'($urandom_range(ROWS * COLS - 1)));
        read_cell(14'(last_start + COLS + $urandom_range(COLS - 1)));
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.mode         = 1'b0;
        in_if.char_code    = 8'd0;
        in_if.cell_address = 14'd0;
        in_if.end_of_write = 1'b0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = 1'b0;
        cfg_if.data        = 16'd0;
        stall_tick         = 0;
        error_count        = 0;
        burst_left         = 0;
        shadow_attr        = ATTR_RESET;
        shadow_blank       = BLANK_RESET;
        shadow_start       = 0;
        shadow_row         = 0;
        shadow_col         = 0;
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_control_bytes();
        test_registers();
        test_bottom_row();
        random_phase(170);
        write_reg(CFG_TEXT_ATTR, 16'($urandom_range(255)));
        write_reg(CFG_BLANK_CELL, 16'($urandom));
        random_phase(170);
        write_reg(CFG_TEXT_ATTR, 16'h00FF);
        write_reg(CFG_BLANK_CELL, 16'hFFFF);
        random_phase(160);
        test_page_wrap();

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_text_console_writer_core passed");
        end else begin
            $display("tb_text_console_writer_core failed");
        end
        $finish;
    end
endmodule

/* text_console_writer_core.f */
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_back.sv
src/text_console_writer_core.sv
tb/tb_text_console_writer_core.sv
